// File: hw/rtl/panel_repack_with_dither_dim_assert.svh
// assertion macros shared by the panel repacker rtl
// included by modules that carry concurrent checks; no other dependencies
`ifndef PANEL_REPACK_WITH_DITHER_DIM_ASSERT_SVH
`define PANEL_REPACK_WITH_DITHER_DIM_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PRDD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PRDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/prdd_pkg.sv
// shared types, constants and lookup functions for the panel repacker
// no dependencies; used by every module of the block
`default_nettype none

package prdd_pkg;

    // geometry
    localparam int WIDTH          = 400;
    localparam int ROW_BYTES      = WIDTH / 8;
    localparam int COL_W          = $clog2(ROW_BYTES);
    localparam int MAX_ROW_GROUPS = 128;
    localparam int GRP_W          = 8;
    localparam int ROW_W          = 9;
    localparam int ADDR_W         = 15;
    localparam int SUB_W          = 2;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;
    localparam int DIM_W     = 7;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_GROUPS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_LEVEL  = 1'd1;
    localparam logic [GRP_W-1:0]     ROW_GROUPS_RST = 8'd75;
    localparam logic [DIM_W-1:0]     DIM_LEVEL_RST  = 7'd64;
    localparam logic [DIM_W-1:0]     DIM_FULL       = 7'd64;

    // row phase inside a four-row group that produces output
    localparam logic [1:0]       PHASE_OUT = 2'd3;
    // last of the four panel bytes per source byte
    localparam logic [SUB_W-1:0] SUB_LAST  = 2'd3;

    // job queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // one fourth-row source byte with the three stored rows above it
    typedef struct packed {
        logic [7:0]       row0;   // bottom row of the group (fresh byte)
        logic [7:0]       row1;
        logic [7:0]       row2;
        logic [7:0]       row3;   // top row of the group
        logic [COL_W-1:0] col;
        logic [2:0]       ry;     // row count modulo 8
        logic [GRP_W-1:0] by;     // group counted from the bottom
        logic             fend;   // last byte of the frame
    } t_job;

    // 8x8 ordered dither thresholds, indexed [row][column]
    localparam logic [5:0] BAYER [0:7][0:7] = '{
        '{6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42},
        '{6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26},
        '{6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38},
        '{6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22},
        '{6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41},
        '{6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25},
        '{6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37},
        '{6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21}
    };

    function automatic logic [5:0] bayer(input logic [2:0] y, input logic [2:0] x);
        return BAYER[y][x];
    endfunction

    // group count clamped to 1..MAX_ROW_GROUPS
    function automatic logic [GRP_W-1:0] eff_groups(input logic [GRP_W-1:0] g);
        logic [GRP_W-1:0] res;
        if (g == '0) begin
            res = GRP_W'(1);
        end else if (g > GRP_W'(MAX_ROW_GROUPS)) begin
            res = GRP_W'(MAX_ROW_GROUPS);
        end else begin
            res = g;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/panel_repack_with_dither_dim.sv
// top level of the panel repacker with ordered-dither dimming
// holds the configuration registers; uses prdd_pkg, prdd_front, prdd_queue, prdd_back
//
// Usage:
//   Input is a queue write side: drive i_pixel_byte with push high; the byte is
//   taken on a clock edge where full is low. Bytes come row-major, MSB first.
//   Results are a queue read side: while empty is low the oldest panel byte is
//   on o_buf_addr/o_buf_byte/o_last_in_run/o_frame_end; pop takes it.
//   Configuration: i_cfg_we with i_cfg_idx (0 row_groups, 1 dim_level) and
//   i_cfg_data writes a register at once; write only while the block is idle.
// Throughput: rows one to three of each group take one byte per cycle while full is
//   low. A fourth-row byte gives four panel bytes, one per cycle while pop is high,
//   set by the single back-end expansion unit; the job queue lets the front end
//   take further bytes meanwhile. Path: job stage, job queue, output register; the
//   first panel byte is followed by the other three, one per cycle while pop is high.
// Reset: clears row and column position, the job stage, the job queue and
//   the output valid flag; row_groups returns to 75 and dim_level to 64. The line
//   banks are not cleared and are always written before they are read.
// Stall: when pop stays low the output register holds, the back end stops,
//   the two-entry job queue and the job stage fill and then full rises.
`default_nettype none

module panel_repack_with_dither_dim (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [7:0]                     i_pixel_byte,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [prdd_pkg::ADDR_W-1:0]         o_buf_addr,
    output logic [7:0]                          o_buf_byte,
    output logic                                o_last_in_run,
    output logic                                o_frame_end,
    input  wire logic                           i_cfg_we,
    input  wire logic [prdd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [prdd_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    logic [prdd_pkg::GRP_W-1:0] r_row_groups;
    logic [prdd_pkg::DIM_W-1:0] r_dim_level;
    logic [prdd_pkg::GRP_W-1:0] groups;

    prdd_pkg::t_job front_job, head_job;
    logic           front_valid, q_full, q_valid, q_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_groups <= prdd_pkg::ROW_GROUPS_RST;
            r_dim_level  <= prdd_pkg::DIM_LEVEL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                prdd_pkg::REG_ROW_GROUPS: r_row_groups <= i_cfg_data[prdd_pkg::GRP_W-1:0];
                prdd_pkg::REG_DIM_LEVEL:  r_dim_level  <= i_cfg_data[prdd_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign groups = prdd_pkg::eff_groups(r_row_groups);

    // front: intake and line banks
    prdd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pixel_byte (i_pixel_byte),
        .o_full       (full),
        .i_groups     (groups),
        .o_job        (front_job),
        .o_job_valid  (front_valid),
        .i_job_full   (q_full)
    );

    // job queue
    prdd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (head_job),
        .o_valid (q_valid)
    );

    // back: expansion and output register
    prdd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (head_job),
        .i_job_valid   (q_valid),
        .o_job_pop     (q_pop),
        .i_groups      (groups),
        .i_dim         (r_dim_level),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_buf_addr    (o_buf_addr),
        .o_buf_byte    (o_buf_byte),
        .o_last_in_run (o_last_in_run),
        .o_frame_end   (o_frame_end)
    );

endmodule

`default_nettype wire

// File: hw/rtl/prdd_front.sv
// front end: takes source bytes, tracks row and column, keeps three rows
// per group in line banks and issues jobs for fourth-row bytes; uses prdd_pkg
`default_nettype none

module prdd_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [7:0]                 i_pixel_byte,
    output logic                            o_full,
    input  wire logic [prdd_pkg::GRP_W-1:0] i_groups,
    output prdd_pkg::t_job                  o_job,
    output logic                            o_job_valid,
    input  wire logic                       i_job_full
);

    logic [prdd_pkg::COL_W-1:0] r_byte_col, n_byte_col;
    logic [prdd_pkg::ROW_W-1:0] r_row_count, n_row_count;
    logic [prdd_pkg::ROW_W:0]   four_g_m1;
    logic [prdd_pkg::ROW_W-1:0] last_row;
    logic                       accept, is_out, row_last, at_last;
    logic [1:0]                 phase;
    logic [prdd_pkg::GRP_W-1:0] by;

    // line banks, one per stored row of a group
    logic [7:0] r_bank0 [0:prdd_pkg::ROW_BYTES-1];
    logic [7:0] r_bank1 [0:prdd_pkg::ROW_BYTES-1];
    logic [7:0] r_bank2 [0:prdd_pkg::ROW_BYTES-1];
    logic [7:0] r_rd0, r_rd1, r_rd2;

    // job stage
    logic                       r_s1_valid;
    logic [7:0]                 r_s1_px;
    logic [prdd_pkg::COL_W-1:0] r_s1_col;
    logic [2:0]                 r_s1_ry;
    logic [prdd_pkg::GRP_W-1:0] r_s1_by;
    logic                       r_s1_fend;

    // classification of the incoming transaction
    assign o_full    = r_s1_valid && i_job_full;
    assign accept    = i_push && !o_full;
    assign phase     = r_row_count[1:0];
    assign is_out    = (phase == prdd_pkg::PHASE_OUT);
    assign row_last  = (r_byte_col == prdd_pkg::COL_W'(prdd_pkg::ROW_BYTES - 1));
    assign four_g_m1 = (prdd_pkg::ROW_W + 1)'({i_groups, 2'b00}) - (prdd_pkg::ROW_W + 1)'(1);
    assign last_row  = four_g_m1[prdd_pkg::ROW_W-1:0];
    assign at_last   = (r_row_count >= last_row);
    assign by        = i_groups - prdd_pkg::GRP_W'(1)
                     - prdd_pkg::GRP_W'(r_row_count[prdd_pkg::ROW_W-1:2]);

    // position counters
    always_comb begin
        n_byte_col  = r_byte_col;
        n_row_count = r_row_count;
        if (accept) begin
            if (row_last) begin
                n_byte_col  = '0;
                n_row_count = at_last ? '0 : r_row_count + prdd_pkg::ROW_W'(1);
            end else begin
                n_byte_col = r_byte_col + prdd_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_col  <= '0;
            r_row_count <= '0;
        end else begin
            r_byte_col  <= n_byte_col;
            r_row_count <= n_row_count;
        end
    end

    // line banks: write on rows one to three, read all on the fourth
    always_ff @(posedge i_clk) begin
        if (accept && phase == 2'd0) begin
            r_bank0[r_byte_col] <= i_pixel_byte;
        end
        if (accept && phase == 2'd1) begin
            r_bank1[r_byte_col] <= i_pixel_byte;
        end
        if (accept && phase == 2'd2) begin
            r_bank2[r_byte_col] <= i_pixel_byte;
        end
        if (accept && is_out) begin
            r_rd0 <= r_bank0[r_byte_col];
            r_rd1 <= r_bank1[r_byte_col];
            r_rd2 <= r_bank2[r_byte_col];
        end
    end

    // job stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept && is_out) begin
            r_s1_valid <= 1'b1;
        end else if (!i_job_full) begin
            r_s1_valid <= 1'b0;
        end
    end

    // job stage payload
    always_ff @(posedge i_clk) begin
        if (accept && is_out) begin
            r_s1_px   <= i_pixel_byte;
            r_s1_col  <= r_byte_col;
            r_s1_ry   <= r_row_count[2:0];
            r_s1_by   <= by;
            r_s1_fend <= row_last && at_last;
        end
    end

    // job assembly
    always_comb begin
        o_job.row0 = r_s1_px;
        o_job.row1 = r_rd2;
        o_job.row2 = r_rd1;
        o_job.row3 = r_rd0;
        o_job.col  = r_s1_col;
        o_job.ry   = r_s1_ry;
        o_job.by   = r_s1_by;
        o_job.fend = r_s1_fend;
    end
    assign o_job_valid = r_s1_valid;

endmodule

`default_nettype wire

// File: hw/rtl/prdd_queue.sv
// two-entry job queue between the front and back of the panel repacker
// depends on prdd_pkg for the job type and depth constants
`default_nettype none

module prdd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire prdd_pkg::t_job i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output prdd_pkg::t_job      o_head,
    output logic                o_valid
);

    prdd_pkg::t_job               r_mem [0:prdd_pkg::Q_DEPTH-1];
    logic [prdd_pkg::Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [prdd_pkg::Q_CNT_W-1:0] r_count;
    logic                         do_push, do_pop;

    assign o_full  = (r_count == prdd_pkg::Q_CNT_W'(prdd_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + prdd_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + prdd_pkg::Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + prdd_pkg::Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - prdd_pkg::Q_CNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/prdd_back.sv
// back end: expands each job into four dithered panel bytes with addresses
// and holds them in the output register; uses prdd_pkg and the assert macros
`default_nettype none
`include "panel_repack_with_dither_dim_assert.svh"

module prdd_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire prdd_pkg::t_job             i_job,
    input  wire logic                       i_job_valid,
    output logic                            o_job_pop,
    input  wire logic [prdd_pkg::GRP_W-1:0] i_groups,
    input  wire logic [prdd_pkg::DIM_W-1:0] i_dim,
    output logic                            o_empty,
    input  wire logic                       i_pop,
    output logic [prdd_pkg::ADDR_W-1:0]     o_buf_addr,
    output logic [7:0]                      o_buf_byte,
    output logic                            o_last_in_run,
    output logic                            o_frame_end
);

    localparam int K_W    = prdd_pkg::COL_W + prdd_pkg::SUB_W;
    localparam int PROD_W = K_W + prdd_pkg::GRP_W;

    logic [prdd_pkg::SUB_W-1:0]  r_sub;
    logic                        r_out_valid;
    logic [prdd_pkg::ADDR_W-1:0] r_out_addr;
    logic [7:0]                  r_out_byte;
    logic                        r_out_last, r_out_fend;

    logic              load, is_last;
    logic [K_W-1:0]    k;
    logic [PROD_W-1:0] prod, addr_sum;
    logic [7:0]        rows [0:3];
    logic [2:0]        src_bit;
    logic [7:0]        pack, mask;

    assign load      = i_job_valid && (!r_out_valid || i_pop);
    assign is_last   = (r_sub == prdd_pkg::SUB_LAST);
    assign o_job_pop = load && is_last;

    // panel address of this column pair
    assign k        = {i_job.col, r_sub};
    assign prod     = PROD_W'(k) * PROD_W'(i_groups);
    assign addr_sum = prod + PROD_W'(i_job.by);

    // bit pack: group row ly goes to pair 3-ly of the panel byte
    assign rows[0] = i_job.row0;
    assign rows[1] = i_job.row1;
    assign rows[2] = i_job.row2;
    assign rows[3] = i_job.row3;
    assign src_bit = {~r_sub, 1'b1};

    always_comb begin
        for (int ly = 0; ly < 4; ly++) begin
            pack[7 - 2 * ly -: 2] = rows[ly][src_bit -: 2];
        end
    end

    // dither mask from the threshold table
    always_comb begin
        for (int ly = 0; ly < 4; ly++) begin
            for (int lx = 0; lx < 2; lx++) begin
                mask[7 - (2 * ly + lx)] = (i_dim >= prdd_pkg::DIM_FULL) ||
                    ({1'b0, prdd_pkg::bayer(i_job.ry - 3'(ly), {r_sub, 1'(lx)})} < i_dim);
            end
        end
    end

    // sub-step counter within a job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_sub <= r_sub + prdd_pkg::SUB_W'(1);
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_addr <= addr_sum[prdd_pkg::ADDR_W-1:0];
            r_out_byte <= ~pack & mask;
            r_out_last <= is_last;
            r_out_fend <= is_last && i_job.fend;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_buf_addr    = r_out_addr;
    assign o_buf_byte    = r_out_byte;
    assign o_last_in_run = r_out_last;
    assign o_frame_end   = r_out_fend;

    // checks
    `PRDD_ASSERT_IMP(a_sub_has_job, i_clk, i_rst_n, r_sub != '0, i_job_valid, "job lost mid-run")
    `PRDD_ASSERT_IMP(a_fend_is_last, i_clk, i_rst_n, r_out_valid && r_out_fend, r_out_last, "frame end not on last byte")
    `PRDD_ASSERT_IMP(a_last_wraps, i_clk, i_rst_n, r_out_valid && r_out_last, r_sub == '0, "sub counter not wrapped")
    `PRDD_ASSERT_NEXT(a_job_held, i_clk, i_rst_n, load && !is_last, i_job_valid, "job dropped before fourth byte")

endmodule

`default_nettype wire

// File: tb/tb_panel_repack_with_dither_dim.sv
// self-checking testbench for panel_repack_with_dither_dim: a directed table, then random
// pixel rows, with bursty input and stalling output; depends on prdd_pkg and the block rtl
module tb_panel_repack_with_dither_dim;

    localparam int LINE_BYTES    = prdd_pkg::ROW_BYTES;
    localparam int GROUPS_CAP    = prdd_pkg::MAX_ROW_GROUPS;
    localparam int ADDR_BITS     = prdd_pkg::ADDR_W;
    localparam int IDX_BITS      = prdd_pkg::CFG_IDX_W;
    localparam int DATA_BITS     = prdd_pkg::CFG_DAT_W;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_BYTES  = 180;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 24;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PRINT_CAP     = 40;

    // ordered dither thresholds, [row & 7][column & 7]
    localparam int DITHER_TH [0:7][0:7] = '{
        '{ 0, 32,  8, 40,  2, 34, 10, 42},
        '{48, 16, 56, 24, 50, 18, 58, 26},
        '{12, 44,  4, 36, 14, 46,  6, 38},
        '{60, 28, 52, 20, 62, 30, 54, 22},
        '{ 3, 35, 11, 43,  1, 33,  9, 41},
        '{51, 19, 59, 27, 49, 17, 57, 25},
        '{15, 47,  7, 39, 13, 45,  5, 37},
        '{63, 31, 55, 23, 61, 29, 53, 21}
    };

    typedef enum logic [1:0] {
        OP_BYTES,
        OP_GROUPS,
        OP_DIM
    } t_plan_op;

    // one line of the directed plan; typed_byte is the panel byte of all four results
    typedef struct packed {
        t_plan_op    op;
        logic [7:0]  value;
        logic [7:0]  count;
        logic        typed;
        logic [7:0]  typed_byte;
    } t_plan_row;

    localparam int PLAN_ROWS = 14;
    localparam t_plan_row PLAN [0:PLAN_ROWS-1] = '{
        // reset configuration, first group: three blank rows then the output row
        '{OP_BYTES,  8'h00, 8'd50, 1'b0, 8'h00},
        '{OP_BYTES,  8'h00, 8'd50, 1'b0, 8'h00},
        '{OP_BYTES,  8'h00, 8'd50, 1'b0, 8'h00},
        '{OP_BYTES,  8'h00, 8'd1,  1'b1, 8'hFF},
        '{OP_BYTES,  8'hFF, 8'd1,  1'b1, 8'h3F},
        '{OP_BYTES,  8'h80, 8'd1,  1'b0, 8'h00},
        '{OP_BYTES,  8'h01, 8'd1,  1'b0, 8'h00},
        // full darkening mid-row
        '{OP_DIM,    8'd0,  8'd0,  1'b0, 8'h00},
        '{OP_BYTES,  8'h5A, 8'd1,  1'b1, 8'h00},
        '{OP_BYTES,  8'hC3, 8'd1,  1'b0, 8'h00},
        // largest group count, dim level above full scale, top address
        '{OP_GROUPS, 8'd128, 8'd0, 1'b0, 8'h00},
        '{OP_DIM,    8'd127, 8'd0, 1'b0, 8'h00},
        '{OP_BYTES,  8'h69, 8'd43, 1'b0, 8'h00},
        '{OP_BYTES,  8'h00, 8'd1,  1'b1, 8'hFF}
    };

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [7:0]           data;
        logic                 last;
        logic                 fend;
    } t_panel_byte;

    // dut connections
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 push          = 1'b0;
    logic                 full;
    logic [7:0]           i_pixel_byte  = 8'h00;
    logic                 empty;
    logic                 pop           = 1'b0;
    logic [ADDR_BITS-1:0] o_buf_addr;
    logic [7:0]           o_buf_byte;
    logic                 o_last_in_run;
    logic                 o_frame_end;
    logic                 i_cfg_we      = 1'b0;
    logic [IDX_BITS-1:0]  i_cfg_idx     = '0;
    logic [DATA_BITS-1:0] i_cfg_data    = '0;

    // typed expectation travels with the byte on the bus
    logic                 typed_on      = 1'b0;
    logic [7:0]           typed_val     = 8'h00;

    // shadow of the repacker state
    logic [7:0]           line_mem [0:2][0:LINE_BYTES-1];
    int                   row_pos       = 0;
    int                   col_pos       = 0;
    logic [7:0]           groups_reg    = prdd_pkg::ROW_GROUPS_RST;
    logic [6:0]           dim_reg       = prdd_pkg::DIM_LEVEL_RST;
    t_panel_byte          panel_bytes_due [$];

    // bookkeeping
    int                   mismatches    = 0;
    int                   bytes_taken   = 0;
    int                   bytes_checked = 0;
    int                   frame_ends    = 0;
    int                   reg_writes    = 0;
    int                   burst_left    = 0;
    int                   quiet_cycles  = 0;
    int                   stall_mode    = 0;
    int                   stall_left    = 0;
    int                   rx_tick       = 0;

    panel_repack_with_dither_dim uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_pixel_byte  (i_pixel_byte),
        .empty         (empty),
        .pop           (pop),
        .o_buf_addr    (o_buf_addr),
        .o_buf_byte    (o_buf_byte),
        .o_last_in_run (o_last_in_run),
        .o_frame_end   (o_frame_end),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("MISMATCH @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        end
    endtask

    // expand one source byte into the panel bytes it yields, and advance the row position
    task automatic pack_panel_bytes(input logic [7:0] px, input logic use_typed,
                                    input logic [7:0] typed_b);
        int               grp;
        int               last_row;
        int               phase;
        int               from_bottom;
        int               k;
        int               sh;
        int               j;
        int               ly;
        int               lx;
        int               y;
        int               x;
        int               addr_full;
        logic [3:0][7:0]  rows;
        logic [7:0]       pack;
        logic [7:0]       keep;
        t_panel_byte      pb;
        if (groups_reg == 8'd0) begin
            grp = 1;
        end else if (int'(groups_reg) > GROUPS_CAP) begin
            grp = GROUPS_CAP;
        end else begin
            grp = int'(groups_reg);
        end
        last_row = 4 * grp - 1;
        phase = row_pos & 3;
        if (phase < 3) begin
            line_mem[phase][col_pos] = px;
        end else begin
            from_bottom = (grp - 1 - (row_pos >> 2)) & 255;
            rows[0] = px;
            rows[1] = line_mem[2][col_pos];
            rows[2] = line_mem[1][col_pos];
            rows[3] = line_mem[0][col_pos];
            for (j = 0; j < 4; j++) begin
                k = col_pos * 4 + j;
                sh = 6 - 2 * j;
                pack = 8'h00;
                keep = 8'h00;
                // bottom row lands in the top bit pair, left column in the high bit
                for (ly = 0; ly < 4; ly++) begin
                    pack[7 - 2 * ly -: 2] = rows[ly][sh +: 2];
                    for (lx = 0; lx < 2; lx++) begin
                        y = (row_pos - ly) & 7;
                        x = (2 * k + lx) & 7;
                        if (dim_reg >= 7'd64 || DITHER_TH[y][x] < int'(dim_reg)) begin
                            keep[7 - (2 * ly + lx)] = 1'b1;
                        end
                    end
                end
                addr_full = k * grp + from_bottom;
                pb.addr = addr_full[ADDR_BITS-1:0];
                pb.data = use_typed ? typed_b : (~pack & keep);
                pb.last = (j == 3);
                pb.fend = (j == 3) && (col_pos == LINE_BYTES - 1) && (row_pos >= last_row);
                panel_bytes_due.push_back(pb);
            end
        end
        if (col_pos + 1 >= LINE_BYTES) begin
            col_pos = 0;
            row_pos = (row_pos >= last_row) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    // monitor: results first, then new input, then register writes
    always @(posedge i_clk) begin : monitor
        t_panel_byte want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (panel_bytes_due.size() == 0) begin
                    report_mismatch("unexpected result, buf_addr", int'(o_buf_addr), 0);
                end else begin
                    want = panel_bytes_due.pop_front();
                    if (o_buf_addr !== want.addr)
                        report_mismatch("buf_addr", int'(o_buf_addr), int'(want.addr));
                    if (o_buf_byte !== want.data)
                        report_mismatch("buf_byte", int'(o_buf_byte), int'(want.data));
                    if (o_last_in_run !== want.last)
                        report_mismatch("last_in_run", int'(o_last_in_run), int'(want.last));
                    if (o_frame_end !== want.fend)
                        report_mismatch("frame_end", int'(o_frame_end), int'(want.fend));
                    if (want.fend)
                        frame_ends++;
                    bytes_checked++;
                end
            end
            if (push && !full) begin
                pack_panel_bytes(i_pixel_byte, typed_on, typed_val);
                bytes_taken++;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == prdd_pkg::REG_ROW_GROUPS) begin
                    groups_reg = i_cfg_data;
                end else if (i_cfg_idx == prdd_pkg::REG_DIM_LEVEL) begin
                    dim_reg = i_cfg_data[6:0];
                end
                reg_writes++;
            end
        end
    end

    // receiver: stall pattern switches among steady, coin-flip, sparse and periodic
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(20, 80);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 1) == 1);
                2: pop <= ($urandom_range(0, 3) == 0);
                default: pop <= ((rx_tick % 5) < 3);
            endcase
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results still due",
                     quiet_cycles, panel_bytes_due.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one source byte; a new burst may open with a gap
    task automatic send_pixel(input logic [7:0] b, input logic typed, input logic [7:0] tb_byte);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push         <= 1'b1;
        i_pixel_byte <= b;
        typed_on     <= typed;
        typed_val    <= tb_byte;
        do @(posedge i_clk); while (full);
    endtask

    // hold input until every due result has arrived, then let the front end settle
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (panel_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [DATA_BITS-1:0] val);
        wait_idle();
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // register index for a plan operation
    function automatic logic [IDX_BITS-1:0] prodx(input t_plan_op op);
        logic [IDX_BITS-1:0] idx;
        if (op == OP_DIM) begin
            idx = prdd_pkg::REG_DIM_LEVEL;
        end else begin
            idx = prdd_pkg::REG_ROW_GROUPS;
        end
        return idx;
    endfunction

    // stimulus
    initial begin : stimulus
        t_plan_row   prow;
        int          i;
        int          sent;
        int          n;
        int          directed_bytes;
        logic [7:0]  g;
        logic [7:0]  d;
        logic [7:0]  b;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (i = 0; i < PLAN_ROWS; i++) begin
            prow = PLAN[i];
            case (prow.op)
                OP_GROUPS: write_reg(prodx(OP_GROUPS), prow.value);
                OP_DIM:    write_reg(prodx(OP_DIM), prow.value);
                default:   repeat (prow.count) send_pixel(prow.value, prow.typed, prow.typed_byte);
            endcase
        end
        directed_bytes = bytes_taken;

        // random phases, each under a fresh setting
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            case ($urandom_range(0, 9))
                0: g = 8'd0;
                1: g = 8'd128;
                2: g = 8'd200;
                3: g = 8'd255;
                4: g = 8'($urandom_range(1, 128));
                default: g = 8'($urandom_range(1, 3));
            endcase
            case ($urandom_range(0, 7))
                0: d = 8'd0;
                1: d = 8'd64;
                2: d = 8'd127;
                3: d = 8'($urandom_range(0, 255));
                default: d = 8'($urandom_range(1, 63));
            endcase
            case ($urandom_range(0, 2))
                0: write_reg(prodx(OP_GROUPS), g);
                1: write_reg(prodx(OP_DIM), d);
                default: begin
                    write_reg(prodx(OP_GROUPS), g);
                    write_reg(prodx(OP_DIM), d);
                end
            endcase
            n = $urandom_range(20, 120);
            if (n > RANDOM_BYTES - sent) begin
                n = RANDOM_BYTES - sent;
            end
            repeat (n) begin
                case ($urandom_range(0, 7))
                    0: b = 8'h00;
                    1: b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_pixel(b, 1'b0, 8'h00);
                sent++;
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
            end
        end

        // drain and watch for stray results
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("summary: %0d source bytes (%0d directed), %0d panel bytes checked",
                 bytes_taken, directed_bytes, bytes_checked);
        $display("summary: %0d frame ends, %0d register writes, %0d mismatches",
                 frame_ends, reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
